/* design/hyperloglog_merge_and_estimate_assert.svh */
// Assertion macros used by the top level of the estimator.
`ifndef HYPERLOGLOG_MERGE_AND_ESTIMATE_ASSERT_SVH
`define HYPERLOGLOG_MERGE_AND_ESTIMATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define HLLME_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define HLLME_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");
`else
`define HLLME_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HLLME_ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

/* design/hllme_pkg.sv */
// Types, constants and helper functions of the cardinality estimator.
`timescale 1ns / 1ps
package hllme_pkg;

  localparam int INDEX_BITS = 10;
  localparam int FRAC_BITS  = 48;
  localparam int NUM_REGS   = 1 << INDEX_BITS;
  localparam int RANK_W     = 6;
  localparam int SUM_W      = INDEX_BITS + FRAC_BITS + 1;
  localparam int ZC_W       = INDEX_BITS + 1;
  localparam int EST_W      = 63;
  localparam int REM_W      = SUM_W + 1;
  localparam int NUM_W      = 128;
  localparam int L_W        = 36;

  localparam logic [63:0] ALPHA_Q32 =
    64'((64'(7213) * 64'(NUM_REGS) << 32) /
        (64'(10) * (64'(1000) * 64'(NUM_REGS) + 64'(1079))));
  localparam logic [NUM_W-1:0] NUMER =
    (128'(ALPHA_Q32) * 128'(NUM_REGS) * 128'(NUM_REGS)) << (FRAC_BITS - 32);
  localparam logic [EST_W-1:0] SMALL_LIMIT = EST_W'((5 * NUM_REGS) >> 1);
  localparam logic [EST_W-1:0] EST_MAX     = {EST_W{1'b1}};
  localparam logic [31:0]      LN2_Q32     = 32'd2977044472;
  localparam logic [L_W-1:0]   L_BASE      = L_W'(INDEX_BITS) << 32;

  localparam logic OP_MERGE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                  is_query;
    logic [INDEX_BITS-1:0] idx;
    logic [RANK_W-1:0]     val;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [ZC_W-1:0]  zc;
  } snap_t;

  typedef struct packed {
    logic            clearing;
    logic [ZC_W-1:0] zero_count;
  } back_status_t;

  typedef enum logic [2:0] {
    EST_IDLE, EST_DIV, EST_CHK, EST_LOG, EST_LN, EST_OUT
  } est_state_t;

  function automatic logic [SUM_W-1:0] term_of(input logic [RANK_W-1:0] r);
    logic [SUM_W-1:0] t;
    t = '0;
    if (r <= RANK_W'(FRAC_BITS)) begin
      t = SUM_W'(1) << (RANK_W'(FRAC_BITS) - r);
    end
    return t;
  endfunction

endpackage

/* design/hllme_front.sv */
// Input side: accepts beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module hllme_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,
  input  logic [0:0]          s_tuser,
  input  logic                clearing,
  output logic                q_valid,
  output hllme_pkg::item_t    q_item,
  input  logic                q_pop
);

  hllme_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign s_tready = (count != 2'd2) && !clearing;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].is_query <= (s_tuser[0] == hllme_pkg::OP_QUERY);
      slots[wr_ptr].idx      <= s_tdata[hllme_pkg::INDEX_BITS-1:0];
      slots[wr_ptr].val      <= s_tdata[15:10];
    end
  end

endmodule

/* design/hllme_back.sv */
// Rank store with max-merge, running harmonic sum and zero-register count.
`timescale 1ns / 1ps
module hllme_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  hllme_pkg::item_t          q_item,
  output logic                      q_pop,
  input  logic                      est_idle,
  output hllme_pkg::snap_t          snap,
  output hllme_pkg::back_status_t   status
);

  logic [hllme_pkg::RANK_W-1:0]     ranks [hllme_pkg::NUM_REGS];
  logic [hllme_pkg::RANK_W-1:0]     rdata;
  logic                             clearing;
  logic [hllme_pkg::INDEX_BITS-1:0] clr_addr;
  logic                             s2_valid;
  logic [hllme_pkg::INDEX_BITS-1:0] s2_idx;
  logic [hllme_pkg::RANK_W-1:0]     s2_val;
  logic                             fw_valid;
  logic [hllme_pkg::INDEX_BITS-1:0] fw_idx;
  logic [hllme_pkg::RANK_W-1:0]     fw_val;
  logic [hllme_pkg::SUM_W-1:0]      sum;
  logic [hllme_pkg::ZC_W-1:0]       zc;
  logic [hllme_pkg::RANK_W-1:0]     old;
  logic                             upd;
  logic                             take_merge;

  // A query leaves the queue only once the merge stage has drained.
  assign q_pop = q_valid && !clearing &&
                 (!q_item.is_query || (!s2_valid && est_idle));
  assign take_merge = q_pop && !q_item.is_query;

  // The write from the cycle before is not yet visible in the read data.
  assign old = (fw_valid && fw_idx == s2_idx) ? fw_val : rdata;
  assign upd = s2_valid && (s2_val > old);

  assign snap.start = q_pop && q_item.is_query;
  assign snap.sum   = sum;
  assign snap.zc    = zc;
  assign status.clearing   = clearing;
  assign status.zero_count = zc;

  always_ff @(posedge clk) begin
    if (clearing) begin
      ranks[clr_addr] <= '0;
    end else if (upd) begin
      ranks[s2_idx] <= s2_val;
    end
    if (take_merge) rdata <= ranks[q_item.idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      s2_valid <= 1'b0;
      fw_valid <= 1'b0;
      sum      <= hllme_pkg::SUM_W'(hllme_pkg::NUM_REGS) << hllme_pkg::FRAC_BITS;
      zc       <= hllme_pkg::ZC_W'(hllme_pkg::NUM_REGS);
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == {hllme_pkg::INDEX_BITS{1'b1}}) clearing <= 1'b0;
      end
      s2_valid <= take_merge;
      fw_valid <= upd;
      if (upd) begin
        sum <= sum - hllme_pkg::term_of(old) + hllme_pkg::term_of(s2_val);
        if (old == '0) zc <= zc - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_merge) begin
      s2_idx <= q_item.idx;
      s2_val <= q_item.val;
    end
    if (upd) begin
      fw_idx <= s2_idx;
      fw_val <= s2_val;
    end
  end

endmodule

/* design/hllme_est.sv */
// Estimate unit: bit-serial divider, squaring log2 unit and the result register.
`timescale 1ns / 1ps
module hllme_est (
  input  logic                      clk,
  input  logic                      rst,
  input  hllme_pkg::snap_t          snap,
  output logic                      est_idle,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [79:0]               m_tdata,
  output logic [0:0]                m_tuser
);

  hllme_pkg::est_state_t state, state_next;

  logic [hllme_pkg::SUM_W-1:0] dvs;
  logic [hllme_pkg::ZC_W-1:0]  zc;
  logic [hllme_pkg::NUM_W-1:0] num;
  logic [hllme_pkg::REM_W-1:0] rem;
  logic [hllme_pkg::EST_W-1:0] quo;
  logic                        ovf;
  logic [6:0]                  dcnt;
  logic [3:0]                  lexp;
  logic [31:0]                 ly;
  logic [31:0]                 lfrac;
  logic [4:0]                  lcnt;
  logic [51:0]                 prod;
  logic                        lin_used;

  logic [hllme_pkg::REM_W-1:0] rem_sh;
  logic                        qbit;
  logic [hllme_pkg::REM_W-1:0] rem_new;
  logic [63:0]                 sq;
  logic                        lbit;
  logic [3:0]                  msb;
  logic                        go_small;
  logic [hllme_pkg::L_W-1:0]   lval;
  logic [63:0]                 ln_wide;
  logic [hllme_pkg::EST_W-1:0] est_val;
  logic                        load_out;

  assign rem_sh  = {rem[hllme_pkg::REM_W-2:0], num[hllme_pkg::NUM_W-1]};
  assign qbit    = (rem_sh >= hllme_pkg::REM_W'(dvs));
  assign rem_new = qbit ? rem_sh - hllme_pkg::REM_W'(dvs) : rem_sh;
  assign sq      = 64'(ly) * 64'(ly);
  assign lbit    = sq[63];
  assign lval    = hllme_pkg::L_BASE - {lexp, lfrac};
  assign ln_wide = (64'(prod[51:16]) << hllme_pkg::INDEX_BITS) >> 32;
  assign est_val = lin_used ? hllme_pkg::EST_W'(ln_wide)
                            : (ovf ? hllme_pkg::EST_MAX : quo);
  assign go_small = !ovf && (zc != '0) &&
                    ((quo < hllme_pkg::SMALL_LIMIT) ||
                     (quo == hllme_pkg::SMALL_LIMIT && rem == '0));

  always_comb begin
    msb = '0;
    for (int i = 0; i < hllme_pkg::ZC_W; i++) begin
      if (zc[i]) msb = 4'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= hllme_pkg::EST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    est_idle   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      hllme_pkg::EST_IDLE: begin
        est_idle = 1'b1;
        if (snap.start) begin
          state_next = (snap.sum == '0) ? hllme_pkg::EST_OUT : hllme_pkg::EST_DIV;
        end
      end
      hllme_pkg::EST_DIV: begin
        if (dcnt == '0) state_next = hllme_pkg::EST_CHK;
      end
      hllme_pkg::EST_CHK: begin
        state_next = go_small ? hllme_pkg::EST_LOG : hllme_pkg::EST_OUT;
      end
      hllme_pkg::EST_LOG: begin
        if (lcnt == '0) state_next = hllme_pkg::EST_LN;
      end
      hllme_pkg::EST_LN: begin
        state_next = hllme_pkg::EST_OUT;
      end
      hllme_pkg::EST_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = hllme_pkg::EST_IDLE;
        end
      end
      default: state_next = hllme_pkg::EST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      hllme_pkg::EST_IDLE: begin
        dvs      <= snap.sum;
        zc       <= snap.zc;
        num      <= hllme_pkg::NUMER;
        rem      <= '0;
        quo      <= '0;
        ovf      <= (snap.sum == '0);
        dcnt     <= 7'd127;
        lin_used <= 1'b0;
      end
      hllme_pkg::EST_DIV: begin
        num  <= num << 1;
        rem  <= rem_new;
        quo  <= {quo[hllme_pkg::EST_W-2:0], qbit};
        if (qbit && dcnt >= 7'd63) ovf <= 1'b1;
        dcnt <= dcnt - 1'b1;
      end
      hllme_pkg::EST_CHK: begin
        lexp  <= msb;
        ly    <= 32'(zc) << (5'd31 - 5'(msb));
        lfrac <= '0;
        lcnt  <= 5'd31;
      end
      hllme_pkg::EST_LOG: begin
        // The square is taken in Q1.31; a result of two or more renormalizes.
        ly    <= lbit ? sq[63:32] : sq[62:31];
        lfrac <= {lfrac[30:0], lbit};
        lcnt  <= lcnt - 1'b1;
      end
      hllme_pkg::EST_LN: begin
        prod     <= 52'(lval[hllme_pkg::L_W-1:16]) * 52'(hllme_pkg::LN2_Q32);
        lin_used <= 1'b1;
      end
      hllme_pkg::EST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'b0, 11'(zc), est_val};
      m_tuser <= lin_used;
    end
  end

endmodule

/* design/hyperloglog_merge_and_estimate.sv */
// Top level of the HyperLogLog merge and estimate block.
//
//   channel  dir  tdata (low bit up)                       tuser
//   s_*      in   reg_index[9:0], reg_value[15:10]         operation
//   m_*      out  estimate[62:0], zero_registers[73:63]    small_range_used
//
// A merge beat is taken every cycle while no clearing pass runs and no query
// waits at the queue head; the rank store is read one cycle and written the next.
// A query waits for the merge stage to drain and the estimate unit to go idle,
// then runs the bit-serial divider and, in the small range, the log2 squaring loop.
// After reset a clearing pass zeroes all 1024 registers of the rank store; s_tready
// is low meanwhile. A waiting result does not stop merges from being taken.
`timescale 1ns / 1ps
`include "hyperloglog_merge_and_estimate_assert.svh"
module hyperloglog_merge_and_estimate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // reg_index[9:0], reg_value[15:10]
  input  logic [0:0]  s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // estimate[62:0], zero_registers[73:63], zero fill
  output logic [0:0]  m_tuser    // small_range_used[0]
);

  logic                     q_valid;
  hllme_pkg::item_t         q_item;
  logic                     q_pop;
  logic                     est_idle;
  hllme_pkg::snap_t         snap;
  hllme_pkg::back_status_t  status;

  hllme_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .clearing (status.clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  hllme_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .est_idle (est_idle),
    .snap     (snap),
    .status   (status)
  );

  hllme_est u_est (
    .clk      (clk),
    .rst      (rst),
    .snap     (snap),
    .est_idle (est_idle),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `HLLME_ASSERT_IMPLY(a_no_accept_while_clearing, clk, rst, status.clearing, !s_tready)
  `HLLME_ASSERT_ALWAYS(a_zero_count_bound, clk, rst,
    status.zero_count <= hllme_pkg::ZC_W'(hllme_pkg::NUM_REGS))
  `HLLME_ASSERT_IMPLY(a_small_needs_zeros, clk, rst, m_tvalid && m_tuser[0],
    m_tdata[73:63] != 11'd0)

endmodule
